/* src/eplm_pkg.sv */
// ----------------------------------------------------------------------------
// eplm_pkg
// Shared types and constants of the edge pair latency meter: opcodes,
// frame types, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package eplm_pkg;

    // Field widths
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned FTYPE_W   = 2;
    localparam int unsigned TMO_W     = 26;
    localparam int unsigned CLK_W     = 29;
    localparam int unsigned CFG_IDX_W = 2;

    // Input opcodes
    localparam logic [OP_W-1:0] OP_STIM    = 3'd0;
    localparam logic [OP_W-1:0] OP_RESP    = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
    localparam logic [OP_W-1:0] OP_REARM   = 3'd3;
    localparam logic [OP_W-1:0] OP_START   = 3'd4;

    // Frame types
    localparam logic [FTYPE_W-1:0] FRM_SAMPLE    = 2'd0;
    localparam logic [FTYPE_W-1:0] FRM_TMO       = 2'd1;
    localparam logic [FTYPE_W-1:0] FRM_BAD_ORDER = 2'd2;
    localparam logic [FTYPE_W-1:0] FRM_DROP      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_HZ  = 2'd3;

    // Register reset values
    localparam logic [STAMP_W-1:0] RST_HOLDOFF = 32'd150000;
    localparam logic [TMO_W-1:0]   RST_TIMEOUT = 26'd100000;
    localparam logic               RST_MODE    = 1'b0;
    localparam logic [CLK_W-1:0]   RST_CLK_HZ  = 29'd150000000;

    // Nanoseconds per tick times clock rate
    localparam logic [30:0] NS_SCALE = 31'd2000000000;

    // Configuration register bundle
    typedef struct packed {
        logic [STAMP_W-1:0] holdoff;
        logic [TMO_W-1:0]   tmo_limit;
        logic               mode;
        logic [CLK_W-1:0]   clock_hz;
    } t_cfg;

endpackage

/* src/eplm_cfg.sv */
// ----------------------------------------------------------------------------
// eplm_cfg
// Configuration register file; write-only, keeps the low bits of each
// register's width.
// ----------------------------------------------------------------------------
module eplm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [eplm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [eplm_pkg::STAMP_W-1:0]     i_cfg_wdata,
    output eplm_pkg::t_cfg                   o_cfg
);

    eplm_pkg::t_cfg r_cfg;
    eplm_pkg::t_cfg n_cfg;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                eplm_pkg::CFG_HOLDOFF: n_cfg.holdoff = i_cfg_wdata;
                eplm_pkg::CFG_TIMEOUT: n_cfg.tmo_limit = i_cfg_wdata[eplm_pkg::TMO_W-1:0];
                eplm_pkg::CFG_MODE:    n_cfg.mode = i_cfg_wdata[0];
                eplm_pkg::CFG_CLK_HZ:  n_cfg.clock_hz = i_cfg_wdata[eplm_pkg::CLK_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holdoff   <= eplm_pkg::RST_HOLDOFF;
            r_cfg.tmo_limit <= eplm_pkg::RST_TIMEOUT;
            r_cfg.mode      <= eplm_pkg::RST_MODE;
            r_cfg.clock_hz  <= eplm_pkg::RST_CLK_HZ;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/eplm_div.sv */
// ----------------------------------------------------------------------------
// eplm_div
// Tick to nanosecond converter: one multiply by the scale constant, then a
// bit-serial restoring division by the clock rate, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module eplm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [30:0]                   i_ticks,
    input  logic [eplm_pkg::CLK_W-1:0]    i_clock_hz,
    output logic                          o_done,
    output logic [eplm_pkg::STAMP_W-1:0]  o_ns
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_CHK  = 2'd2;
    localparam logic [1:0] D_RUN  = 2'd3;

    logic [1:0]                   r_phase, n_phase;
    logic [30:0]                  r_ticks, n_ticks;
    logic [61:0]                  r_prod, n_prod;
    logic [eplm_pkg::CLK_W-1:0]   r_rem, n_rem;
    logic [31:0]                  r_dq, n_dq;
    logic [4:0]                   r_cnt, n_cnt;
    logic                         r_done, n_done;

    logic [eplm_pkg::CLK_W:0]     w_trial;
    logic [eplm_pkg::CLK_W+1:0]   w_diff;
    logic                         w_sat;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign w_trial = {r_rem, r_dq[31]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_clock_hz};
    // Quotient overflows 32 bits when the high dividend word reaches the divisor
    assign w_sat   = r_prod[61:32] >= {1'b0, i_clock_hz};

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_phase)
            D_IDLE: begin
                if (i_start) begin
                    n_ticks = i_ticks;
                    n_phase = D_MUL;
                end
            end
            D_MUL: begin
                n_prod  = 62'(r_ticks) * 62'(eplm_pkg::NS_SCALE);
                n_phase = D_CHK;
            end
            D_CHK: begin
                if (w_sat) begin
                    n_dq    = '1;
                    n_done  = 1'b1;
                    n_phase = D_IDLE;
                end else begin
                    n_rem   = r_prod[32 +: eplm_pkg::CLK_W];
                    n_dq    = r_prod[31:0];
                    n_cnt   = 5'd31;
                    n_phase = D_RUN;
                end
            end
            D_RUN: begin
                if (!w_diff[eplm_pkg::CLK_W+1]) begin
                    n_rem = w_diff[eplm_pkg::CLK_W-1:0];
                    n_dq  = {r_dq[30:0], 1'b1};
                end else begin
                    n_rem = w_trial[eplm_pkg::CLK_W-1:0];
                    n_dq  = {r_dq[30:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_done  = 1'b1;
                    n_phase = D_IDLE;
                end
            end
            default: n_phase = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_ticks <= n_ticks;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_cnt   <= n_cnt;
    end

    assign o_done = r_done;
    assign o_ns   = r_dq;

endmodule

/* src/edge_pair_latency_meter.sv */
// Result path: a dropped, timeout or order-error result is staged, then moved into the
// output register once it is free; a sample first passes the multiply and the 32-step
// divider (skipped when the latency saturates). Throughput: an item with no result is
// taken every cycle; an item with a result holds off the next until the output takes it.
// Reset (synchronous, active low) clears pending state, sequence count and output valid,
// and loads the register reset values.
// ----------------------------------------------------------------------------
// edge_pair_latency_meter
// Pairs stimulus and response edge timestamps into latency frames, with
// debounce, dropped, timeout and order error reporting.
// ----------------------------------------------------------------------------
module edge_pair_latency_meter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [eplm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_wdata,
    // input items
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [63:0]                    i_s_tdata,  // [31:0] timestamp, [63:32] time_us
    input  logic [2:0]                     i_s_tuser,  // [2:0] opcode
    // result items
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [127:0]                   o_m_tdata,  // [31:0] sequence_res,
                                                       // [63:32] stimulus_stamp,
                                                       // [95:64] response_stamp,
                                                       // [127:96] latency_ns
    output logic [2:0]                     o_m_tuser   // [1:0] frame_type, [2] channel_mode
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    eplm_pkg::t_cfg w_cfg;

    // Control and measurement state
    logic [1:0]  r_state, n_state;
    logic        r_pending, n_pending;
    logic        r_have_prev, n_have_prev;
    logic [31:0] r_pstamp, n_pstamp;
    logic [31:0] r_pnum, n_pnum;
    logic [31:0] r_pstart, n_pstart;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_seq, n_seq;

    // Staged result
    logic [1:0]  r_res_type, n_res_type;
    logic        r_res_mode, n_res_mode;
    logic [31:0] r_res_seq, n_res_seq;
    logic [31:0] r_res_stim, n_res_stim;
    logic [31:0] r_res_resp, n_res_resp;
    logic [31:0] r_res_lat, n_res_lat;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_user, n_out_user;
    logic [127:0] r_out_data, n_out_data;

    logic        w_accept;
    logic [2:0]  w_op;
    logic [31:0] w_ts;
    logic [31:0] w_now;
    logic [31:0] w_dt;
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_div_ns;
    logic        w_out_free;

    assign w_op       = i_s_tuser;
    assign w_ts       = i_s_tdata[31:0];
    assign w_now      = i_s_tdata[63:32];
    assign w_dt       = w_ts - r_pstamp;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    eplm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    eplm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_ticks    (w_dt[30:0]),
        .i_clock_hz (w_cfg.clock_hz),
        .o_done     (w_div_done),
        .o_ns       (w_div_ns)
    );

    // Item decode and sequencing
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_have_prev = r_have_prev;
        n_pstamp    = r_pstamp;
        n_pnum      = r_pnum;
        n_pstart    = r_pstart;
        n_prev      = r_prev;
        n_seq       = r_seq;
        n_res_type  = r_res_type;
        n_res_mode  = r_res_mode;
        n_res_seq   = r_res_seq;
        n_res_stim  = r_res_stim;
        n_res_resp  = r_res_resp;
        n_res_lat   = r_res_lat;
        w_div_start = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // every result reports the measurement open before this item
                    n_res_mode = w_cfg.mode;
                    n_res_seq  = r_pnum;
                    n_res_stim = r_pstamp;
                    n_res_resp = '0;
                    n_res_lat  = '0;
                    unique case (w_op)
                        eplm_pkg::OP_STIM: begin
                            // debounce against the previous accepted stimulus
                            if (!(r_have_prev && ((w_ts - r_prev) < w_cfg.holdoff))) begin
                                if (r_pending) begin
                                    n_res_type = eplm_pkg::FRM_DROP;
                                    n_state    = ST_WAIT;
                                end
                                n_prev      = w_ts;
                                n_have_prev = 1'b1;
                                n_pending   = 1'b1;
                                n_pstamp    = w_ts;
                                n_seq       = r_seq + 32'd1;
                                n_pnum      = r_seq + 32'd1;
                                n_pstart    = w_now;
                            end
                        end
                        eplm_pkg::OP_RESP: begin
                            if (r_pending) begin
                                n_pending  = 1'b0;
                                n_res_resp = w_ts;
                                if (w_dt[31]) begin
                                    n_res_type = eplm_pkg::FRM_BAD_ORDER;
                                    n_state    = ST_WAIT;
                                end else begin
                                    n_res_type  = eplm_pkg::FRM_SAMPLE;
                                    w_div_start = 1'b1;
                                    n_state     = ST_DIV;
                                end
                            end
                        end
                        eplm_pkg::OP_TICK: begin
                            if (r_pending && ((w_now - r_pstart) > 32'(w_cfg.tmo_limit))) begin
                                n_pending  = 1'b0;
                                n_res_type = eplm_pkg::FRM_TMO;
                                n_state    = ST_WAIT;
                            end
                        end
                        eplm_pkg::OP_REARM: begin
                            n_pending   = 1'b0;
                            n_have_prev = 1'b0;
                        end
                        eplm_pkg::OP_START: begin
                            n_pending   = 1'b0;
                            n_have_prev = 1'b0;
                            n_seq       = '0;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_res_lat = w_div_ns;
                    n_state   = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // move the staged result into the output register once it is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = {r_res_mode, r_res_type};
                    n_out_data  = {r_res_lat, r_res_resp, r_res_stim, r_res_seq};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= 1'b0;
            r_have_prev <= 1'b0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_have_prev <= n_have_prev;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_pstamp   <= n_pstamp;
        r_pnum     <= n_pnum;
        r_pstart   <= n_pstart;
        r_prev     <= n_prev;
        r_res_type <= n_res_type;
        r_res_mode <= n_res_mode;
        r_res_seq  <= n_res_seq;
        r_res_stim <= n_res_stim;
        r_res_resp <= n_res_resp;
        r_res_lat  <= n_res_lat;
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // divider finishes only while a sample is being converted
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider done outside conversion");

    // only samples carry a latency
    a_lat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[1:0] != eplm_pkg::FRM_SAMPLE)) |-> (o_m_tdata[127:96] == '0))
        else $error("non-sample frame with nonzero latency");

    // timeout and dropped frames carry no response stamp
    a_resp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser[1:0] == eplm_pkg::FRM_TMO) ||
                        (o_m_tuser[1:0] == eplm_pkg::FRM_DROP)))
        |-> (o_m_tdata[95:64] == '0))
        else $error("timeout or dropped frame with response stamp");

    // a start item zeroes the sequence and closes any measurement
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == eplm_pkg::OP_START)) |=> ((r_seq == '0) && !r_pending))
        else $error("start item did not clear state");
`endif

endmodule
